// File: src/rrpt_pkg.sv
// Package for the round robin process table core.
// Command and result word types, action codes and fixed constants.
// No dependencies.
package rrpt_pkg;

  // Action codes carried in the command word
  localparam logic [2:0] ACT_TICK       = 3'd0;
  localparam logic [2:0] ACT_SPAWN      = 3'd1;
  localparam logic [2:0] ACT_SPAWN_WAIT = 3'd2;
  localparam logic [2:0] ACT_KILL       = 3'd3;
  localparam logic [2:0] ACT_TERMINATE  = 3'd4;

  // Stack pointer of a slot that has never been written
  localparam logic [15:0] STACK_RESET = 16'hff00;
  // Segment of the kernel, also the spacing between process segments
  localparam logic [15:0] SEG_STEP    = 16'h1000;

  typedef struct packed {
    logic [2:0]  action;
    logic        from_kernel;
    logic [2:0]  running_slot;
    logic [15:0] saved_stack;
    logic [2:0]  target_slot;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  chosen_slot;
    logic        kept_previous;
    logic [15:0] next_segment;
    logic [15:0] next_stack;
  } res_t;

endpackage

// File: src/rrpt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rrpt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/round_robin_process_table_core.sv
// Round robin process table core: top level.
// Depends on rrpt_pkg (types, codes, constants) and rrpt_ram (stack and link stores).
//
// Keeps a table of SLOTS process slots and the current slot. A command word is
// taken when start is high and busy is low; exactly one result word follows,
// shown on result for a single cycle while done is high, and it must be taken
// then, as the receiver cannot hold it off. A tick saves the interrupted stack
// pointer and scans round robin for a runnable slot; spawn and spawn-and-wait
// take the lowest free slot; kill and terminate free a slot and unblock its
// parent. A tick or spawn scans one slot per clock, then reads the chosen slot's stack
// and gives the result; spawn-and-wait first writes the links (S_LINK1, S_LINK2). A
// scan that finds nothing answers at the last slot; kill and terminate pass S_KREAD,
// S_KRD and S_KCLR; a kill beyond the table or an unused action code answers straight
// from idle. The stack and link stores each have one write and one read port with a
// registered read. done can coincide with the next start being accepted. The stores
// need no clearing after reset. init_stack is to be written through cfg_valid /
// cfg_data (cfg_ready is always high) while the block is idle, unenforced by the block.
module round_robin_process_table_core
  import rrpt_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd,
  output logic        done,
  output res_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int IW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 2);
  localparam logic [LW-1:0] LINK_NONE = LW'(SLOTS);
  localparam logic [LW-1:0] LINK_BLK  = LW'(SLOTS + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TSCAN,
    S_SSCAN,
    S_LINK1,
    S_LINK2,
    S_KREAD,
    S_KRD,
    S_KCLR,
    S_READ,
    S_OUT
  } state_t;

  state_t         state;
  cmd_t           cmd_q;
  logic [IW-1:0]  scan;
  logic [IW-1:0]  cnt;
  logic [IW-1:0]  sel;
  logic [IW-1:0]  current;
  logic [15:0]    init_stack;
  logic [SLOTS-1:0] active;
  logic [SLOTS-1:0] blocked;
  logic [SLOTS-1:0] stk_vld;
  logic [SLOTS-1:0] lnk_vld;
  logic           stk_rvld;
  logic           lnk_rvld;

  logic           accept;
  logic           save_run;
  logic [IW-1:0]  scan_start;
  logic [IW-1:0]  scan_next;
  logic           scan_last;

  logic           stk_we;
  logic [IW-1:0]  stk_waddr;
  logic [15:0]    stk_wdata;
  logic [15:0]    stk_rdata;
  logic [15:0]    stk_val;

  logic           lnk_we;
  logic [IW-1:0]  lnk_waddr;
  logic [LW-1:0]  lnk_wdata;
  logic [LW-1:0]  lnk_rdata;
  logic [LW-1:0]  parent;
  logic           parent_ok;

  // Segment of a slot, wrapping to 16 bits
  function automatic logic [15:0] seg_of(input logic [3:0] slot);
    seg_of = {slot + 4'd2, 12'h000};
  endfunction

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Tick from a user process inside the table: save its stack, scan from the next slot
  assign save_run   = (cmd.action == ACT_TICK) && !cmd.from_kernel &&
                      (int'(cmd.running_slot) < SLOTS);
  assign scan_start = !save_run ? '0 :
                      (int'(cmd.running_slot) == SLOTS - 1) ? '0 :
                      IW'(cmd.running_slot) + 1'b1;
  assign scan_next  = (scan == LAST_SLOT) ? '0 : scan + 1'b1;
  assign scan_last  = (cnt == LAST_SLOT);

  // Entries never written read as their reset values
  assign stk_val   = stk_rvld ? stk_rdata : STACK_RESET;
  assign parent    = lnk_rvld ? lnk_rdata : LINK_NONE;
  assign parent_ok = (parent < LW'(SLOTS));

  // Stack store write port
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = sel;
    stk_wdata = init_stack;
    if (accept && save_run) begin
      stk_we    = 1'b1;
      stk_waddr = IW'(cmd.running_slot);
      stk_wdata = cmd.saved_stack;
    end else if (state == S_KRD) begin
      stk_we    = 1'b1;
    end
  end

  // Link store write port
  always_comb begin
    lnk_we    = 1'b0;
    lnk_waddr = sel;
    lnk_wdata = LINK_NONE;
    case (state)
      S_LINK1: begin
        lnk_we    = 1'b1;
        lnk_wdata = LW'(current);
      end
      S_LINK2: begin
        lnk_we    = 1'b1;
        lnk_waddr = current;
        lnk_wdata = LINK_BLK;
      end
      S_KRD: begin
        lnk_we    = parent_ok;
        lnk_waddr = parent[IW-1:0];
      end
      S_KCLR: begin
        lnk_we    = 1'b1;
      end
      default: begin
        lnk_we    = 1'b0;
      end
    endcase
  end

  rrpt_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (sel),
    .rdata (stk_rdata)
  );

  rrpt_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (sel),
    .rdata (lnk_rdata)
  );

  // Written marks and the blocked mirror of the link store
  always_ff @(posedge clk) begin
    if (rst) begin
      stk_vld  <= '0;
      lnk_vld  <= '0;
      blocked  <= '0;
      stk_rvld <= 1'b0;
      lnk_rvld <= 1'b0;
    end else begin
      stk_rvld <= stk_vld[sel];
      lnk_rvld <= lnk_vld[sel];
      if (stk_we) begin
        stk_vld[stk_waddr] <= 1'b1;
      end
      if (lnk_we) begin
        lnk_vld[lnk_waddr] <= 1'b1;
        blocked[lnk_waddr] <= (lnk_wdata == LINK_BLK);
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      init_stack <= STACK_RESET;
    end else if (cfg_valid) begin
      init_stack <= cfg_data;
    end
  end

  // Command sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      active  <= '0;
      current <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q <= cmd;
            cnt   <= '0;
            case (cmd.action)
              ACT_TICK: begin
                scan  <= scan_start;
                state <= S_TSCAN;
              end
              ACT_SPAWN, ACT_SPAWN_WAIT: begin
                scan  <= '0;
                state <= S_SSCAN;
              end
              ACT_KILL: begin
                if (int'(cmd.target_slot) < SLOTS) begin
                  sel   <= IW'(cmd.target_slot);
                  state <= S_KREAD;
                end else begin
                  result <= '0;
                  done   <= 1'b1;
                end
              end
              ACT_TERMINATE: begin
                sel   <= current;
                state <= S_KREAD;
              end
              default: begin
                result <= '0;
                done   <= 1'b1;
              end
            endcase
          end
        end
        // Round robin scan for an active, unblocked slot
        S_TSCAN: begin
          if (active[scan] && !blocked[scan]) begin
            sel     <= scan;
            current <= scan;
            state   <= S_READ;
          end else if (scan_last) begin
            // status, chosen_slot, kept_previous, next_segment, next_stack
            result <= {1'b0, 3'd0, 1'b1,
                       cmd_q.from_kernel ? SEG_STEP : seg_of({1'b0, cmd_q.running_slot}),
                       cmd_q.saved_stack};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            scan <= scan_next;
            cnt  <= cnt + 1'b1;
          end
        end
        // Lowest free slot
        S_SSCAN: begin
          if (!active[scan]) begin
            active[scan] <= 1'b1;
            sel          <= scan;
            state        <= (cmd_q.action == ACT_SPAWN_WAIT) ? S_LINK1 : S_READ;
          end else if (scan_last) begin
            result <= {1'b1, 3'd0, 1'b0, 16'h0000, 16'h0000};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            scan <= scan_next;
            cnt  <= cnt + 1'b1;
          end
        end
        // New slot gets the current one as parent, then the current one blocks
        S_LINK1: begin
          state <= S_LINK2;
        end
        S_LINK2: begin
          state <= S_READ;
        end
        // Free a slot: read its parent, reset its stack, unlink both
        S_KREAD: begin
          state <= S_KRD;
        end
        S_KRD: begin
          active[sel] <= 1'b0;
          state       <= S_KCLR;
        end
        S_KCLR: begin
          result <= '0;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_READ: begin
          state <= S_OUT;
        end
        // Resume word for the chosen slot
        S_OUT: begin
          result <= {1'b0, 3'(sel), 1'b0, seg_of(4'(sel)), stk_val};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
